[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the grid interpolator.
// No dependencies; bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/lgi_pkg.sv]
// Package of the grid interpolator: command codes, status struct, constants.
// No dependencies.
package lgi_pkg;

    localparam int FIELD_NUM = 5;
    localparam int F_W       = 3;

    localparam logic signed [31:0] W_ONE = 32'sd16777216;   // 1.0 in Q7.24
    localparam logic signed [31:0] W_MAX = 32'sd2147483647;

    localparam logic [3:0]  STENCIL_RESET     = 4'd4;
    localparam logic [10:0] POINT_COUNT_RESET = 11'd1024;

    localparam logic CFG_STENCIL_SIZE = 1'b0;
    localparam logic CFG_POINT_COUNT  = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [4:0] t_cmd;

    localparam t_cmd CMD_NONE    = 5'd0;
    localparam t_cmd CMD_LOAD    = 5'd1;
    localparam t_cmd CMD_QUERY   = 5'd2;
    localparam t_cmd CMD_END0    = 5'd3;
    localparam t_cmd CMD_END1    = 5'd4;
    localparam t_cmd CMD_BIS_RD  = 5'd5;
    localparam t_cmd CMD_BIS_UPD = 5'd6;
    localparam t_cmd CMD_NEAR    = 5'd7;
    localparam t_cmd CMD_WI_RD   = 5'd8;
    localparam t_cmd CMD_WI_LD   = 5'd9;
    localparam t_cmd CMD_WJ_SKIP = 5'd10;
    localparam t_cmd CMD_WJ_RD   = 5'd11;
    localparam t_cmd CMD_WJ_LD   = 5'd12;
    localparam t_cmd CMD_DSET    = 5'd13;
    localparam t_cmd CMD_DSTEP   = 5'd14;
    localparam t_cmd CMD_DFIN    = 5'd15;
    localparam t_cmd CMD_MUL     = 5'd16;
    localparam t_cmd CMD_WUPD    = 5'd17;
    localparam t_cmd CMD_WSTORE  = 5'd18;
    localparam t_cmd CMD_AC_RD   = 5'd19;
    localparam t_cmd CMD_AC_MUL  = 5'd20;
    localparam t_cmd CMD_AC_ADD  = 5'd21;
    localparam t_cmd CMD_FINISH  = 5'd22;
    localparam t_cmd CMD_OUTSIDE = 5'd23;

    typedef struct packed {
        logic outside;
        logic bis_more;
        logic j_end;
        logic j_self;
        logic i_last;
        logic skip_div;
        logic div_last;
        logic f_last;
    } t_status;

endpackage

[rtl/core/lagrange_grid_interpolator.sv]
// Top level of the Lagrange grid interpolator: configuration registers,
// sequencer and datapath. Depends on lgi_pkg, lgi_ctrl, lgi_datapath, assert_macros.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  item in  | start & !busy          | i_kind, i_point_index, i_grid_coord,
//           |                        | i_value_*, i_query_coord, i_query_tag
//  result   | o_done (one cycle)     | o_interp_*, o_nearest_index,
//           |                        | o_result_tag, o_status
//  config   | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A load item is written to the grid at the accepting edge; busy stays low.
// A query bisects the n points, forms the s stencil weights from the pairwise
// ratios and accumulates the fields; the 32-step restoring divider of the weight
// ratios sets its length. Pairs that need no division skip the divider.
// Reset is synchronous, active low; the grid memories are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module lagrange_grid_interpolator import lgi_pkg::*; #(
    parameter int GRID_DEPTH  = 1024,
    parameter int MAX_STENCIL = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [9:0]         i_point_index,
    input  logic signed [31:0] i_grid_coord,
    input  logic signed [31:0] i_value_phi,
    input  logic signed [31:0] i_value_radial_deriv,
    input  logic signed [31:0] i_value_momentum,
    input  logic signed [31:0] i_value_metric,
    input  logic signed [31:0] i_value_lapse,
    input  logic signed [31:0] i_query_coord,
    input  logic [9:0]         i_query_tag,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [31:0] o_interp_phi,
    output logic signed [31:0] o_interp_radial_deriv,
    output logic signed [31:0] o_interp_momentum,
    output logic signed [31:0] o_interp_metric,
    output logic signed [31:0] o_interp_lapse,
    output logic [9:0]         o_nearest_index,
    output logic [9:0]         o_result_tag,
    output logic               o_status
);

    logic [3:0]  r_stencil_size;
    logic [10:0] r_point_count;
    t_cmd        cmd;
    t_status     status;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stencil_size <= STENCIL_RESET;
            r_point_count  <= POINT_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STENCIL_SIZE: r_stencil_size <= i_cfg_data[3:0];
                CFG_POINT_COUNT:  r_point_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lgi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    lgi_datapath #(
        .GRID_DEPTH  (GRID_DEPTH),
        .MAX_STENCIL (MAX_STENCIL)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_stencil_size        (r_stencil_size),
        .i_point_count         (r_point_count),
        .i_point_index         (i_point_index),
        .i_grid_coord          (i_grid_coord),
        .i_value_phi           (i_value_phi),
        .i_value_radial_deriv  (i_value_radial_deriv),
        .i_value_momentum      (i_value_momentum),
        .i_value_metric        (i_value_metric),
        .i_value_lapse         (i_value_lapse),
        .i_query_coord         (i_query_coord),
        .i_query_tag           (i_query_tag),
        .o_status              (status),
        .o_interp_phi          (o_interp_phi),
        .o_interp_radial_deriv (o_interp_radial_deriv),
        .o_interp_momentum     (o_interp_momentum),
        .o_interp_metric       (o_interp_metric),
        .o_interp_lapse        (o_interp_lapse),
        .o_nearest_index       (o_nearest_index),
        .o_result_tag          (o_result_tag),
        .o_status_flag         (o_status)
    );

    // a result is shown only once the sequencer is back in idle
    `ASSERT_IMPLIES(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // a query item always starts the sequencer
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_kind, busy)
    // a load item gives no result and keeps the block idle
    `ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, start && !busy && !i_kind, !busy && !o_done)
    // an outside query reports a zero index
    `ASSERT_IMPLIES(a_outside_zero, i_clk, i_rst_n, o_done && o_status, o_nearest_index == 10'd0)

endmodule

[rtl/core/lgi_ctrl.sv]
// Sequencer of the grid interpolator: issues one datapath command per cycle.
// Depends on lgi_pkg.
module lgi_ctrl import lgi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_kind,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy,
    output logic    o_done
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_END0 = 5'd1;
    localparam logic [4:0] S_END1 = 5'd2;
    localparam logic [4:0] S_CHK  = 5'd3;
    localparam logic [4:0] S_BIS  = 5'd4;
    localparam logic [4:0] S_BISW = 5'd5;
    localparam logic [4:0] S_NEAR = 5'd6;
    localparam logic [4:0] S_WI   = 5'd7;
    localparam logic [4:0] S_WIL  = 5'd8;
    localparam logic [4:0] S_WJ   = 5'd9;
    localparam logic [4:0] S_WJL  = 5'd10;
    localparam logic [4:0] S_DSET = 5'd11;
    localparam logic [4:0] S_DIV  = 5'd12;
    localparam logic [4:0] S_DFIN = 5'd13;
    localparam logic [4:0] S_MUL  = 5'd14;
    localparam logic [4:0] S_WUPD = 5'd15;
    localparam logic [4:0] S_AR   = 5'd16;
    localparam logic [4:0] S_AM   = 5'd17;
    localparam logic [4:0] S_AA   = 5'd18;
    localparam logic [4:0] S_FIN  = 5'd19;
    localparam logic [4:0] S_OUT  = 5'd20;

    logic [4:0] r_state, n_state;
    logic       r_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_QUERY) begin
                        o_cmd   = CMD_QUERY;
                        n_state = S_END0;
                    end else begin
                        o_cmd = CMD_LOAD;
                    end
                end
            end
            S_END0: begin o_cmd = CMD_END0; n_state = S_END1; end
            S_END1: begin o_cmd = CMD_END1; n_state = S_CHK; end
            S_CHK:  n_state = i_status.outside ? S_OUT : S_BIS;
            S_BIS: begin
                if (i_status.bis_more) begin
                    o_cmd   = CMD_BIS_RD;
                    n_state = S_BISW;
                end else begin
                    n_state = S_NEAR;
                end
            end
            S_BISW: begin o_cmd = CMD_BIS_UPD; n_state = S_BIS; end
            S_NEAR: begin o_cmd = CMD_NEAR;    n_state = S_WI; end
            S_WI:   begin o_cmd = CMD_WI_RD;   n_state = S_WIL; end
            S_WIL:  begin o_cmd = CMD_WI_LD;   n_state = S_WJ; end
            S_WJ: begin
                if (i_status.j_end) begin
                    o_cmd   = CMD_WSTORE;
                    n_state = i_status.i_last ? S_AR : S_WI;
                end else if (i_status.j_self) begin
                    o_cmd = CMD_WJ_SKIP;
                end else begin
                    o_cmd   = CMD_WJ_RD;
                    n_state = S_WJL;
                end
            end
            S_WJL:  begin o_cmd = CMD_WJ_LD; n_state = S_DSET; end
            S_DSET: begin
                o_cmd   = CMD_DSET;
                n_state = i_status.skip_div ? S_MUL : S_DIV;
            end
            S_DIV: begin
                o_cmd = CMD_DSTEP;
                if (i_status.div_last) n_state = S_DFIN;
            end
            S_DFIN: begin o_cmd = CMD_DFIN;   n_state = S_MUL; end
            S_MUL:  begin o_cmd = CMD_MUL;    n_state = S_WUPD; end
            S_WUPD: begin o_cmd = CMD_WUPD;   n_state = S_WJ; end
            S_AR:   begin o_cmd = CMD_AC_RD;  n_state = S_AM; end
            S_AM:   begin o_cmd = CMD_AC_MUL; n_state = S_AA; end
            S_AA: begin
                o_cmd = CMD_AC_ADD;
                if (!i_status.f_last) n_state = S_AM;
                else n_state = i_status.i_last ? S_FIN : S_AR;
            end
            S_FIN:  begin o_cmd = CMD_FINISH;  n_state = S_IDLE; end
            S_OUT:  begin o_cmd = CMD_OUTSIDE; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN) || (r_state == S_OUT);
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

[rtl/core/lgi_datapath.sv]
// Datapath of the grid interpolator: grid memories, bisection, weight divider,
// multiplier and accumulators. Depends on lgi_pkg.
module lgi_datapath import lgi_pkg::*; #(
    parameter int GRID_DEPTH  = 1024,
    parameter int MAX_STENCIL = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [3:0]         i_stencil_size,
    input  logic [10:0]        i_point_count,
    input  logic [9:0]         i_point_index,
    input  logic signed [31:0] i_grid_coord,
    input  logic signed [31:0] i_value_phi,
    input  logic signed [31:0] i_value_radial_deriv,
    input  logic signed [31:0] i_value_momentum,
    input  logic signed [31:0] i_value_metric,
    input  logic signed [31:0] i_value_lapse,
    input  logic signed [31:0] i_query_coord,
    input  logic [9:0]         i_query_tag,
    output t_status            o_status,
    output logic signed [31:0] o_interp_phi,
    output logic signed [31:0] o_interp_radial_deriv,
    output logic signed [31:0] o_interp_momentum,
    output logic signed [31:0] o_interp_metric,
    output logic signed [31:0] o_interp_lapse,
    output logic [9:0]         o_nearest_index,
    output logic [9:0]         o_result_tag,
    output logic               o_status_flag
);

    localparam int AW = $clog2(GRID_DEPTH);
    localparam int CW = $clog2(GRID_DEPTH + 1);
    localparam int SW = $clog2(MAX_STENCIL + 1);
    localparam int IX = $clog2(MAX_STENCIL);
    localparam int RW = FIELD_NUM * 32;

    // grid memories
    logic [31:0]   coord_mem [GRID_DEPTH];
    logic [RW-1:0] field_mem [GRID_DEPTH];
    logic [31:0]   r_coord_rd;
    logic [RW-1:0] r_field_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    logic signed [31:0] r_q;
    logic [9:0]         r_tag;
    logic [CW-1:0]      r_n;
    logic [SW-1:0]      r_s, r_i, r_j;
    logic [AW-1:0]      r_j1, r_j2, r_mid, r_nearest, r_start;
    logic signed [32:0] r_x1, r_x2, r_xi, r_num, r_den;
    logic signed [31:0] r_w, r_r;
    logic signed [31:0] r_weight [MAX_STENCIL];
    logic [31:0]        r_rem, r_dlo, r_quo, r_ad;
    logic               r_neg;
    logic [4:0]         r_cnt;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc [FIELD_NUM];
    logic [F_W-1:0]     r_f;

    logic signed [31:0] out_f [FIELD_NUM];
    logic [9:0]         r_o_near, r_o_tag;
    logic               r_o_stat;

    // combinational helpers
    logic [31:0]        n_clamp, s_clamp, pc_ext, ss_ext;
    logic [31:0]        near_ext, half, st_a, st_cap;
    logic [AW-1:0]      mid, near_sel;
    logic signed [32:0] diff_rd, diff_xi;
    logic [32:0]        ax1, ax2;
    logic [32:0]        num_abs, den_abs;
    logic               den_zero, ovf, neg;
    logic [32:0]        rem2;
    logic               ge;
    logic signed [63:0] sh24, acc_term;
    logic signed [31:0] w_sat, r_fin, field_sel;

    assign wr_en = (i_cmd == CMD_LOAD) && (32'(i_point_index) < GRID_DEPTH);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            coord_mem[AW'(i_point_index)] <= i_grid_coord;
            field_mem[AW'(i_point_index)] <= {i_value_lapse, i_value_metric, i_value_momentum,
                                              i_value_radial_deriv, i_value_phi};
        end
        r_coord_rd <= coord_mem[rd_addr];
        r_field_rd <= field_mem[rd_addr];
    end

    assign mid = AW'(({1'b0, r_j1} + {1'b0, r_j2}) >> 1);

    // the stencil row stays addressed while its five fields are accumulated
    always_comb begin
        case (i_cmd)
            CMD_END0:  rd_addr = AW'(r_n - CW'(1));
            CMD_BIS_RD: rd_addr = mid;
            CMD_WI_RD: rd_addr = r_start + AW'(r_i);
            CMD_WJ_RD: rd_addr = r_start + AW'(r_j);
            CMD_AC_RD, CMD_AC_MUL, CMD_AC_ADD: rd_addr = r_start + AW'(r_i);
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        pc_ext = 32'(i_point_count);
        if (pc_ext < 32'd2) n_clamp = 32'd2;
        else if (pc_ext > GRID_DEPTH) n_clamp = 32'(GRID_DEPTH);
        else n_clamp = pc_ext;
        ss_ext = 32'(i_stencil_size);
        if (ss_ext < 32'd2) s_clamp = 32'd2;
        else if (ss_ext > MAX_STENCIL) s_clamp = 32'(MAX_STENCIL);
        else s_clamp = ss_ext;
        if (s_clamp > n_clamp) s_clamp = n_clamp;
    end

    assign diff_rd = 33'(r_q) - 33'(signed'(r_coord_rd));
    assign diff_xi = r_xi - 33'(signed'(r_coord_rd));

    // nearest point and stencil start
    assign ax1      = r_x1[32] ? 33'(-r_x1) : 33'(r_x1);
    assign ax2      = r_x2[32] ? 33'(-r_x2) : 33'(r_x2);
    assign near_sel = (ax1 < ax2) ? r_j1 : r_j2;
    always_comb begin
        near_ext = 32'(near_sel);
        half     = 32'(r_s) >> 1;
        st_a     = (near_ext > half + 32'd1) ? near_ext - half - 32'd1 : 32'd0;
        st_cap   = 32'(r_n) - 32'(r_s);
        if (st_a > st_cap) st_a = st_cap;
    end

    // divider setup
    assign num_abs  = r_num[32] ? 33'(-r_num) : 33'(r_num);
    assign den_abs  = r_den[32] ? 33'(-r_den) : 33'(r_den);
    assign den_zero = (r_den == '0);
    assign ovf      = {8'd0, num_abs[31:0]} >= {den_abs[31:0], 8'd0};
    assign neg      = r_num[32] ^ r_den[32];

    assign rem2 = {r_rem, r_dlo[31]};
    assign ge   = rem2 >= {1'b0, r_ad};

    always_comb begin
        if (r_quo[31]) r_fin = r_neg ? -W_MAX : W_MAX;
        else r_fin = r_neg ? -signed'(r_quo) : signed'(r_quo);
    end

    assign sh24 = r_prod >>> 24;
    always_comb begin
        if (sh24 > 64'(W_MAX)) w_sat = W_MAX;
        else if (sh24 < -64'(W_MAX)) w_sat = -W_MAX;
        else w_sat = sh24[31:0];
    end

    assign field_sel = r_field_rd[32 * 32'(r_f) +: 32];
    assign acc_term  = r_prod >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i   <= '0;
            r_j   <= '0;
            r_f   <= '0;
            r_cnt <= '0;
        end else begin
            case (i_cmd)
                CMD_QUERY: begin
                    r_q  <= i_query_coord;
                    r_tag <= i_query_tag;
                    r_n  <= CW'(n_clamp);
                    r_s  <= SW'(s_clamp);
                    r_j1 <= '0;
                    r_j2 <= AW'(n_clamp - 32'd1);
                end
                CMD_END0: r_x1 <= diff_rd;
                CMD_END1: r_x2 <= diff_rd;
                CMD_BIS_RD: r_mid <= mid;
                CMD_BIS_UPD: begin
                    if ((diff_rd < 0 && r_x1 > 0) || (diff_rd > 0 && r_x1 < 0)) begin
                        r_j2 <= r_mid;
                        r_x2 <= diff_rd;
                    end else begin
                        r_j1 <= r_mid;
                        r_x1 <= diff_rd;
                    end
                end
                CMD_NEAR: begin
                    r_nearest <= near_sel;
                    r_start   <= AW'(st_a);
                    r_i       <= '0;
                end
                CMD_WI_LD: begin
                    r_xi <= 33'(signed'(r_coord_rd));
                    r_w  <= W_ONE;
                    r_j  <= '0;
                end
                CMD_WJ_SKIP: r_j <= r_j + SW'(1);
                CMD_WJ_LD: begin
                    r_num <= diff_rd;
                    r_den <= diff_xi;
                end
                CMD_DSET: begin
                    r_ad  <= den_abs[31:0];
                    r_neg <= neg;
                    r_rem <= {8'd0, num_abs[31:8]};
                    r_dlo <= {num_abs[7:0], 24'd0};
                    r_quo <= '0;
                    r_cnt <= '0;
                    if (den_zero) r_r <= '0;
                    else if (ovf) r_r <= neg ? -W_MAX : W_MAX;
                end
                CMD_DSTEP: begin
                    r_rem <= ge ? 32'(rem2 - {1'b0, r_ad}) : rem2[31:0];
                    r_quo <= {r_quo[30:0], ge};
                    r_dlo <= r_dlo << 1;
                    r_cnt <= r_cnt + 5'd1;
                end
                CMD_DFIN: r_r <= r_fin;
                CMD_MUL:  r_prod <= r_w * r_r;
                CMD_WUPD: begin
                    r_w <= w_sat;
                    r_j <= r_j + SW'(1);
                end
                CMD_WSTORE: begin
                    r_weight[r_i[IX-1:0]] <= r_w;
                    if (o_status.i_last) begin
                        r_i <= '0;
                        for (int k = 0; k < FIELD_NUM; k++) r_acc[k] <= '0;
                    end else begin
                        r_i <= r_i + SW'(1);
                    end
                end
                CMD_AC_RD: r_f <= '0;
                CMD_AC_MUL: r_prod <= field_sel * r_weight[r_i[IX-1:0]];
                CMD_AC_ADD: begin
                    r_acc[r_f] <= r_acc[r_f] + acc_term;
                    if (o_status.f_last) r_i <= r_i + SW'(1);
                    else r_f <= r_f + F_W'(1);
                end
                CMD_FINISH: begin
                    for (int k = 0; k < FIELD_NUM; k++) begin
                        if (r_acc[k] > 64'sd2147483647) out_f[k] <= 32'sh7fffffff;
                        else if (r_acc[k] < -64'sd2147483648) out_f[k] <= 32'sh80000000;
                        else out_f[k] <= r_acc[k][31:0];
                    end
                    r_o_near <= 10'(r_nearest);
                    r_o_tag  <= r_tag;
                    r_o_stat <= 1'b0;
                end
                CMD_OUTSIDE: begin
                    for (int k = 0; k < FIELD_NUM; k++) out_f[k] <= '0;
                    r_o_near <= '0;
                    r_o_tag  <= r_tag;
                    r_o_stat <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_status.outside  = (r_x1 > 0 && r_x2 > 0) || (r_x1 < 0 && r_x2 < 0);
    assign o_status.bis_more = {1'b0, r_j2} > ({1'b0, r_j1} + (AW+1)'(1));
    assign o_status.j_end    = (r_j == r_s);
    assign o_status.j_self   = (r_j == r_i);
    assign o_status.i_last   = (r_i == r_s - SW'(1));
    assign o_status.skip_div = den_zero || ovf;
    assign o_status.div_last = (r_cnt == 5'd31);
    assign o_status.f_last   = (r_f == F_W'(FIELD_NUM - 1));

    assign o_interp_phi          = out_f[0];
    assign o_interp_radial_deriv = out_f[1];
    assign o_interp_momentum     = out_f[2];
    assign o_interp_metric       = out_f[3];
    assign o_interp_lapse        = out_f[4];
    assign o_nearest_index       = r_o_near;
    assign o_result_tag          = r_o_tag;
    assign o_status_flag         = r_o_stat;

endmodule
